[rtl/core/mmet_pkg.sv]
// Shared types, constants and fixed-point helpers for the Mobius-premapped escape-time unit.
package mmet_pkg;

    localparam int FRAC_BITS = 56;
    localparam int DW        = 64;
    localparam int CW        = 16;
    localparam int MAG_W     = 2 * DW;
    localparam int ACC_W     = MAG_W + 2;
    localparam int DIV_STEPS = MAG_W + FRAC_BITS;
    localparam int DIV_CW    = $clog2(DIV_STEPS);
    localparam int IDX_W     = 3;

    typedef logic signed [DW-1:0]    q_t;
    typedef logic [MAG_W-1:0]        mag_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_ABS,
        ST_RND,
        ST_DIV,
        ST_LOOP
    } state_t;

    // Dot-product operations run on the shared multiplier
    typedef enum logic [3:0] {
        OP_TR,
        OP_TI,
        OP_DEN,
        OP_NR,
        OP_NI,
        OP_KR,
        OP_KI,
        OP_NRM,
        OP_SQR,
        OP_SQI
    } op_t;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_POLE_RE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_POLE_IM   = 3'd1;
    localparam logic [IDX_W-1:0] REG_ZOOM      = 3'd2;
    localparam logic [IDX_W-1:0] REG_CENTER_RE = 3'd3;
    localparam logic [IDX_W-1:0] REG_CENTER_IM = 3'd4;
    localparam logic [IDX_W-1:0] REG_MAX_ITER  = 3'd5;

    // Reset values
    localparam q_t RST_POLE_RE   = 64'sd108086391056891904;
    localparam q_t RST_POLE_IM   = 64'sd57646075230342349;
    localparam q_t RST_ZOOM      = 64'sd2426226128658;
    localparam q_t RST_CENTER_RE = -64'sd54007267727440472;
    localparam q_t RST_CENTER_IM = 64'sd2675954853938003;
    localparam logic [CW-1:0] RST_MAX_ITER = 16'd5000;

    localparam q_t   Q_MAX   = {1'b0, {(DW-1){1'b1}}};
    localparam q_t   Q_MIN   = {1'b1, {(DW-1){1'b0}}};
    localparam mag_t ESC_LIM = mag_t'(100) << (2 * FRAC_BITS);
    localparam mag_t HALF    = mag_t'(1) << (FRAC_BITS - 1);

    // Saturating add
    function automatic q_t sat_add(input q_t a, input q_t b);
        q_t r;
        r = a + b;
        if (a[DW-1] == b[DW-1] && r[DW-1] != a[DW-1])
            return a[DW-1] ? Q_MIN : Q_MAX;
        return r;
    endfunction

    // Saturating subtract
    function automatic q_t sat_sub(input q_t a, input q_t b);
        q_t r;
        r = a - b;
        if (a[DW-1] != b[DW-1] && r[DW-1] != a[DW-1])
            return a[DW-1] ? Q_MIN : Q_MAX;
        return r;
    endfunction

    // Sign and magnitude back to saturated two's complement
    function automatic q_t sat_mag(input logic neg, input logic ovf, input logic [DW-1:0] m);
        logic [DW-1:0] lim;
        logic [DW-1:0] mm;
        lim = neg ? Q_MIN : Q_MAX;
        mm  = (ovf || m > lim) ? lim : m;
        return neg ? q_t'(-mm) : q_t'(mm);
    endfunction

    // Round half away from zero, drop fraction, saturate
    function automatic q_t to_q(input logic neg, input mag_t m);
        logic [MAG_W:0] s;
        logic [MAG_W:0] sh;
        s  = {1'b0, m} + {1'b0, HALF};
        sh = s >> FRAC_BITS;
        return sat_mag(neg, |sh[MAG_W:DW], sh[DW-1:0]);
    endfunction

endpackage

[rtl/core/mobius_mandelbrot_escape_time_unit.sv]
// Escape-time unit: Mobius premap of a plane point followed by Mandelbrot iteration.
//
// A request is taken when start is high and busy is low; its result appears on the
// result ports for one cycle with done high, and must be captured then. A point that
// sits on the pole gives its result in the next cycle; any other point is first premapped,
// then iterated until it escapes or the iteration count reaches max_iter. The run time
// depends on the single 32x32 multiplier, which forms every 64x64 product as four
// partial products, and on the one-bit-a-cycle divider, which takes 184 steps for each
// of the two quotients of the premap.
// Configuration writes are always ready and must be issued only while the unit is idle.
module mobius_mandelbrot_escape_time_unit
    import mmet_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  q_t                point_re,
    input  q_t                point_im,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [DW-1:0]     cfg_data,
    output logic              done,
    output logic [CW-1:0]     escape_count,
    output logic              inside_res,
    output q_t                mapped_re,
    output q_t                mapped_im
);

    // Control registers
    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [2:0]          mac_cnt_reg, mac_cnt_next;
    logic [DIV_CW-1:0]   div_cnt_reg, div_cnt_next;
    logic                done_reg, done_next;

    // Configuration
    q_t                  pole_re_reg, pole_im_reg, zoom_reg, center_re_reg, center_im_reg;
    logic [CW-1:0]       max_iter_reg;

    // Datapath registers
    q_t pr_reg, pr_next, pi_reg, pi_next, dr_reg, dr_next, di_reg, di_next;
    q_t tr_reg, tr_next, ti_reg, ti_next, ur_reg, ur_next, ui_reg, ui_next;
    q_t cr_reg, cr_next, ci_reg, ci_next, xr_reg, xr_next, xi_reg, xi_next;
    acc_t          acc_reg, acc_next;
    mag_t          mag_reg, mag_next, den_reg, den_next, num_reg, num_next;
    mag_t          rem_reg, rem_next;
    logic          sign_reg, sign_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] count_reg, count_next;
    logic          inside_reg, inside_next;
    q_t            map_re_reg, map_re_next, map_im_reg, map_im_next;

    // Shared multiplier signals
    q_t            op_a, op_b;
    logic          op_neg;
    logic [DW-1:0] mag_a, mag_b;
    logic [31:0]   half_a, half_b;
    logic [DW-1:0] pp;
    logic [1:0]    shamt;
    acc_t          pp_ext, acc_sum;
    logic          term_neg;

    // Other combinational values
    acc_t          acc_abs;
    mag_t          abs_mag;
    q_t            q_val, d_re, d_im, div_res;
    mag_t          r_sh;
    logic [DW-1:0] quo_new;
    logic          ovf_new;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done         = done_reg;
    assign escape_count = count_reg;
    assign inside_res   = inside_reg;
    assign mapped_re    = map_re_reg;
    assign mapped_im    = map_im_reg;

    // Operand selection per operation and term
    always_comb
    begin
        op_a   = '0;
        op_b   = '0;
        op_neg = 1'b0;
        unique case (op_reg)
            OP_TR:
            begin
                op_a   = mac_cnt_reg[2] ? pi_reg : pr_reg;
                op_b   = mac_cnt_reg[2] ? pole_im_reg : pole_re_reg;
                op_neg = mac_cnt_reg[2];
            end
            OP_TI:
            begin
                op_a = mac_cnt_reg[2] ? pi_reg : pr_reg;
                op_b = mac_cnt_reg[2] ? pole_re_reg : pole_im_reg;
            end
            OP_DEN:
            begin
                op_a = mac_cnt_reg[2] ? di_reg : dr_reg;
                op_b = op_a;
            end
            OP_NR:
            begin
                op_a = mac_cnt_reg[2] ? ti_reg : tr_reg;
                op_b = mac_cnt_reg[2] ? di_reg : dr_reg;
            end
            OP_NI:
            begin
                op_a   = mac_cnt_reg[2] ? tr_reg : ti_reg;
                op_b   = mac_cnt_reg[2] ? di_reg : dr_reg;
                op_neg = mac_cnt_reg[2];
            end
            OP_KR:
            begin
                op_a = mac_cnt_reg[2] ? q_t'(0) : zoom_reg;
                op_b = ur_reg;
            end
            OP_KI:
            begin
                op_a = mac_cnt_reg[2] ? q_t'(0) : zoom_reg;
                op_b = ui_reg;
            end
            OP_NRM:
            begin
                op_a = mac_cnt_reg[2] ? xi_reg : xr_reg;
                op_b = op_a;
            end
            OP_SQR:
            begin
                op_a   = mac_cnt_reg[2] ? xi_reg : xr_reg;
                op_b   = op_a;
                op_neg = mac_cnt_reg[2];
            end
            OP_SQI:
            begin
                op_a = mac_cnt_reg[2] ? xi_reg : xr_reg;
                op_b = mac_cnt_reg[2] ? xr_reg : xi_reg;
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    // One 32x32 partial product per cycle into the accumulator
    always_comb
    begin
        mag_a    = op_a[DW-1] ? (DW'(0) - op_a) : op_a;
        mag_b    = op_b[DW-1] ? (DW'(0) - op_b) : op_b;
        half_a   = mac_cnt_reg[0] ? mag_a[DW-1:32] : mag_a[31:0];
        half_b   = mac_cnt_reg[1] ? mag_b[DW-1:32] : mag_b[31:0];
        pp       = DW'(half_a) * DW'(half_b);
        shamt    = {1'b0, mac_cnt_reg[0]} + {1'b0, mac_cnt_reg[1]};
        pp_ext   = ACC_W'(pp) << {shamt, 5'b0};
        term_neg = op_a[DW-1] ^ op_b[DW-1] ^ op_neg;
        acc_sum  = term_neg ? (acc_reg - pp_ext) : (acc_reg + pp_ext);
    end

    // Sign/magnitude, rounding and divider step
    always_comb
    begin
        acc_abs = acc_reg[ACC_W-1] ? (ACC_W'(0) - acc_reg) : acc_reg;
        abs_mag = acc_abs[MAG_W-1:0];
        q_val   = to_q(sign_reg, mag_reg);
        d_re    = sat_sub(point_re, pole_re_reg);
        d_im    = sat_sub(point_im, pole_im_reg);
        r_sh    = {rem_reg[MAG_W-2:0], num_reg[MAG_W-1]};
        ovf_new = ovf_reg | quo_reg[DW-1];
        quo_new = {quo_reg[DW-2:0], (r_sh >= den_reg)};
        div_res = sat_mag(sign_reg, ovf_new, quo_new);
    end

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        mac_cnt_next = mac_cnt_reg;
        div_cnt_next = div_cnt_reg;
        done_next    = 1'b0;
        pr_next = pr_reg; pi_next = pi_reg; dr_next = dr_reg; di_next = di_reg;
        tr_next = tr_reg; ti_next = ti_reg; ur_next = ur_reg; ui_next = ui_reg;
        cr_next = cr_reg; ci_next = ci_reg; xr_next = xr_reg; xi_next = xi_reg;
        acc_next  = acc_reg;
        mag_next  = mag_reg;
        sign_next = sign_reg;
        den_next  = den_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        count_next  = count_reg;
        inside_next = inside_reg;
        map_re_next = map_re_reg;
        map_im_next = map_im_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    pr_next = point_re;
                    pi_next = point_im;
                    dr_next = d_re;
                    di_next = d_im;
                    if (d_re == '0 && d_im == '0)
                    begin
                        // point on the pole
                        count_next  = '0;
                        inside_next = 1'b0;
                        map_re_next = '0;
                        map_im_next = '0;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        op_next      = OP_TR;
                        state_next   = ST_MAC;
                        acc_next     = '0;
                        mac_cnt_next = '0;
                    end
                end
            end
            ST_MAC:
            begin
                acc_next     = acc_sum;
                mac_cnt_next = mac_cnt_reg + 3'd1;
                if (mac_cnt_reg == 3'd7)
                    state_next = ST_ABS;
            end
            ST_ABS:
            begin
                sign_next = acc_reg[ACC_W-1];
                mag_next  = abs_mag;
                state_next = ST_RND;
                unique case (op_reg)
                    OP_DEN:
                    begin
                        den_next     = abs_mag;
                        op_next      = OP_NR;
                        state_next   = ST_MAC;
                        acc_next     = '0;
                        mac_cnt_next = '0;
                    end
                    OP_NR, OP_NI:
                    begin
                        num_next     = abs_mag;
                        rem_next     = '0;
                        quo_next     = '0;
                        ovf_next     = 1'b0;
                        div_cnt_next = '0;
                        state_next   = ST_DIV;
                    end
                    OP_NRM:
                    begin
                        if (abs_mag >= ESC_LIM)
                        begin
                            // escaped
                            count_next  = cnt_reg;
                            inside_next = 1'b0;
                            map_re_next = cr_reg;
                            map_im_next = ci_reg;
                            done_next   = 1'b1;
                            state_next  = ST_IDLE;
                        end
                        else
                        begin
                            op_next      = OP_SQR;
                            state_next   = ST_MAC;
                            acc_next     = '0;
                            mac_cnt_next = '0;
                        end
                    end
                    default:
                    begin
                        state_next = ST_RND;
                    end
                endcase
            end
            ST_RND:
            begin
                state_next   = ST_MAC;
                acc_next     = '0;
                mac_cnt_next = '0;
                unique case (op_reg)
                    OP_TR:
                    begin
                        tr_next = q_val;
                        op_next = OP_TI;
                    end
                    OP_TI:
                    begin
                        ti_next = q_val;
                        op_next = OP_DEN;
                    end
                    OP_KR:
                    begin
                        cr_next = sat_sub(center_re_reg, q_val);
                        op_next = OP_KI;
                    end
                    OP_KI:
                    begin
                        ci_next    = sat_sub(center_im_reg, q_val);
                        xr_next    = cr_reg;
                        xi_next    = sat_sub(center_im_reg, q_val);
                        cnt_next   = '0;
                        state_next = ST_LOOP;
                    end
                    OP_SQR:
                    begin
                        tr_next = q_val;
                        op_next = OP_SQI;
                    end
                    OP_SQI:
                    begin
                        xr_next    = sat_add(tr_reg, cr_reg);
                        xi_next    = sat_add(q_val, ci_reg);
                        cnt_next   = cnt_reg + CW'(1);
                        state_next = ST_LOOP;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                num_next     = num_reg << 1;
                rem_next     = (r_sh >= den_reg) ? (r_sh - den_reg) : r_sh;
                quo_next     = quo_new;
                ovf_next     = ovf_new;
                div_cnt_next = div_cnt_reg + DIV_CW'(1);
                if (div_cnt_reg == DIV_CW'(DIV_STEPS - 1))
                begin
                    state_next   = ST_MAC;
                    acc_next     = '0;
                    mac_cnt_next = '0;
                    if (op_reg == OP_NR)
                    begin
                        ur_next = div_res;
                        op_next = OP_NI;
                    end
                    else
                    begin
                        ui_next = div_res;
                        op_next = OP_KR;
                    end
                end
            end
            ST_LOOP:
            begin
                if (cnt_reg >= max_iter_reg)
                begin
                    count_next  = cnt_reg;
                    inside_next = 1'b1;
                    map_re_next = cr_reg;
                    map_im_next = ci_reg;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    op_next      = OP_NRM;
                    state_next   = ST_MAC;
                    acc_next     = '0;
                    mac_cnt_next = '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_TR;
            mac_cnt_reg <= '0;
            div_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            mac_cnt_reg <= mac_cnt_next;
            div_cnt_reg <= div_cnt_next;
            done_reg    <= done_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_re_reg   <= RST_POLE_RE;
            pole_im_reg   <= RST_POLE_IM;
            zoom_reg      <= RST_ZOOM;
            center_re_reg <= RST_CENTER_RE;
            center_im_reg <= RST_CENTER_IM;
            max_iter_reg  <= RST_MAX_ITER;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_POLE_RE:   pole_re_reg   <= cfg_data;
                REG_POLE_IM:   pole_im_reg   <= cfg_data;
                REG_ZOOM:      zoom_reg      <= cfg_data;
                REG_CENTER_RE: center_re_reg <= cfg_data;
                REG_CENTER_IM: center_im_reg <= cfg_data;
                REG_MAX_ITER:  max_iter_reg  <= cfg_data[CW-1:0];
                default:       ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        pr_reg <= pr_next; pi_reg <= pi_next; dr_reg <= dr_next; di_reg <= di_next;
        tr_reg <= tr_next; ti_reg <= ti_next; ur_reg <= ur_next; ui_reg <= ui_next;
        cr_reg <= cr_next; ci_reg <= ci_next; xr_reg <= xr_next; xi_reg <= xi_next;
        acc_reg    <= acc_next;
        mag_reg    <= mag_next;
        sign_reg   <= sign_next;
        den_reg    <= den_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        ovf_reg    <= ovf_next;
        cnt_reg    <= cnt_next;
        count_reg  <= count_next;
        inside_reg <= inside_next;
        map_re_reg <= map_re_next;
        map_im_reg <= map_im_next;
    end

    // A result strobe only comes while the unit is idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result strobe while busy");

    // A flagged result reports exactly the iteration limit
    a_inside_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && inside_reg) |-> (count_reg == max_iter_reg))
        else $error("inside result with wrong count");

    // An accepted request either finishes at once or keeps the unit busy
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done_reg))
        else $error("request dropped");

    // Divider step count stays in range
    a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_cnt_reg < DIV_CW'(DIV_STEPS)))
        else $error("divider step count overrun");

    // Iteration count never passes the limit
    a_cnt_lim: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOP) |-> (cnt_reg <= max_iter_reg))
        else $error("iteration count past limit");

endmodule
